FILE: sv/zgic_pkg.sv
// Shared types, codes and checksum helper functions for the zlib/gzip integrity checker.
`default_nettype none

package zgic_pkg;

   localparam logic [1:0] CMD_BEGIN   = 2'd0;
   localparam logic [1:0] CMD_DATA    = 2'd1;
   localparam logic [1:0] CMD_TRAILER = 2'd2;

   localparam logic [1:0] MODE_RAW  = 2'd0;
   localparam logic [1:0] MODE_ZLIB = 2'd1;
   localparam logic [1:0] MODE_GZIP = 2'd2;

   localparam logic [2:0] STATUS_OK           = 3'd0;
   localparam logic [2:0] STATUS_HEADER_BAD   = 3'd1;
   localparam logic [2:0] STATUS_METHOD_BAD   = 3'd2;
   localparam logic [2:0] STATUS_CHECK_BAD    = 3'd3;
   localparam logic [2:0] STATUS_SIZE_BAD     = 3'd4;

   localparam logic [16:0] ADLER_MOD      = 17'd65521;
   localparam logic [31:0] CRC_POLY       = 32'hEDB88320;
   localparam logic [31:0] ALL_ONES       = 32'hFFFFFFFF;
   localparam logic [3:0]  METHOD_DEFLATE = 4'd8;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  data_byte;
      logic [15:0] header_word;
      logic [31:0] trailer_check;
      logic [31:0] trailer_size;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] running_check;
   } rsp_payload_type;

   // One byte through the reflected CRC-32, bit by bit.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // As 32 is one more than 31, summing the 5-bit digits keeps the residue modulo 31.
   function automatic logic header_divisible(input logic [15:0] hdr);
      logic [6:0] s1;
      logic [5:0] s2;
      s1 = {2'd0, hdr[4:0]} + {2'd0, hdr[9:5]} + {2'd0, hdr[14:10]} + {6'd0, hdr[15]};
      s2 = {1'b0, s1[4:0]} + {4'd0, s1[6:5]};
      return (s2 == 6'd0) || (s2 == 6'd31);
   endfunction

endpackage

`default_nettype wire

FILE: sv/zgic_in_stage.sv
// Input register stage: captures one request beat and holds it until the core takes it.
`default_nettype none

module zgic_in_stage (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire zgic_pkg::req_payload_type req_payload,
   output logic                          stage_valid,
   output zgic_pkg::req_payload_type     stage_payload,
   input  wire logic                     stage_take
);
   import zgic_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   req_payload_type payload_ff;
   logic            stage_free;

   assign stage_free = !valid_ff || stage_take;
   assign req_stall  = !stage_free;
   assign valid_in   = stage_free ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (stage_free && req_valid) begin
         payload_ff <= req_payload;
      end
   end

   assign stage_valid   = valid_ff;
   assign stage_payload = payload_ff;

endmodule

`default_nettype wire

FILE: sv/zgic_core.sv
// Checksum state, combinational update logic and the result register.
`default_nettype none

module zgic_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_write_enable,
   input  wire logic [1:0]               csr_write_data,
   input  wire logic                     stage_valid,
   input  wire zgic_pkg::req_payload_type stage_payload,
   output logic                          stage_take,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output zgic_pkg::rsp_payload_type     rsp_payload
);
   import zgic_pkg::*;

   logic [1:0]      mode_ff;
   logic [15:0]     adler_low_ff, adler_low_in;
   logic [15:0]     adler_high_ff, adler_high_in;
   logic [31:0]     crc_ff, crc_in;
   logic [31:0]     total_ff, total_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic            zlib_mode, gzip_mode;
   logic [16:0]     low_sum, low_mod;
   logic [16:0]     high_sum, high_mod;

   assign zlib_mode  = (mode_ff == MODE_ZLIB);
   assign gzip_mode  = (mode_ff == MODE_GZIP);
   assign stage_take = stage_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (stage_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      adler_low_in  = adler_low_ff;
      adler_high_in = adler_high_ff;
      crc_in        = crc_ff;
      total_in      = total_ff;
      rsp_payload_in.status = STATUS_OK;

      low_sum  = {1'b0, adler_low_ff} + {9'd0, stage_payload.data_byte};
      low_mod  = (low_sum >= ADLER_MOD) ? (low_sum - ADLER_MOD) : low_sum;
      high_sum = {1'b0, adler_high_ff} + low_mod;
      high_mod = (high_sum >= ADLER_MOD) ? (high_sum - ADLER_MOD) : high_sum;

      case (stage_payload.cmd)
         CMD_BEGIN: begin
            adler_low_in  = 16'd1;
            adler_high_in = 16'd0;
            crc_in        = ALL_ONES;
            total_in      = 32'd0;
            if (zlib_mode) begin
               if (!header_divisible(stage_payload.header_word)) begin
                  rsp_payload_in.status = STATUS_HEADER_BAD;
               end else if (stage_payload.header_word[11:8] != METHOD_DEFLATE) begin
                  rsp_payload_in.status = STATUS_METHOD_BAD;
               end
            end
         end
         CMD_DATA: begin
            if (zlib_mode) begin
               adler_low_in  = low_mod[15:0];
               adler_high_in = high_mod[15:0];
            end else if (gzip_mode) begin
               crc_in   = crc_byte(crc_ff, stage_payload.data_byte);
               total_in = total_ff + 32'd1;
            end
         end
         CMD_TRAILER: begin
            if (zlib_mode) begin
               if (stage_payload.trailer_check != {adler_high_ff, adler_low_ff}) begin
                  rsp_payload_in.status = STATUS_CHECK_BAD;
               end
            end else if (gzip_mode) begin
               if (stage_payload.trailer_check != (crc_ff ^ ALL_ONES)) begin
                  rsp_payload_in.status = STATUS_CHECK_BAD;
               end else if (stage_payload.trailer_size != total_ff) begin
                  rsp_payload_in.status = STATUS_SIZE_BAD;
               end
            end
         end
         default: begin
         end
      endcase

      if (zlib_mode) begin
         rsp_payload_in.running_check = {adler_high_in, adler_low_in};
      end else if (gzip_mode) begin
         rsp_payload_in.running_check = crc_in;
      end else begin
         rsp_payload_in.running_check = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_RAW;
         adler_low_ff  <= 16'd1;
         adler_high_ff <= 16'd0;
         crc_ff        <= ALL_ONES;
         total_ff      <= 32'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
         if (stage_take) begin
            adler_low_ff  <= adler_low_in;
            adler_high_ff <= adler_high_in;
            crc_ff        <= crc_in;
            total_ff      <= total_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (stage_take) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

FILE: sv/zlib_gzip_integrity_checker.sv
// A request beat waits in the input stage register; the core then registers its result.
// Throughput: one request beat per cycle while results flow; the byte update is combinational:
// Adler-32 add-and-reduce or eight unrolled CRC-32 bit steps between two registers.
// Backpressure on the result channel stalls the request channel once both registers are full.
// Synchronous active-high reset empties both registers, sets the mode to raw and clears
// the running sums; no clearing pass is needed.
`default_nettype none

module zlib_gzip_integrity_checker (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire zgic_pkg::req_payload_type req_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output zgic_pkg::rsp_payload_type     rsp_payload,
   input  wire logic                     csr_write_enable,
   input  wire logic [1:0]               csr_write_data
);
   import zgic_pkg::*;

   logic            stage_valid;
   logic            stage_take;
   req_payload_type stage_payload;

   zgic_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .stage_valid   (stage_valid),
      .stage_payload (stage_payload),
      .stage_take    (stage_take)
   );

   zgic_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .stage_valid      (stage_valid),
      .stage_payload    (stage_payload),
      .stage_take       (stage_take),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload)
   );

endmodule

`default_nettype wire

FILE: sv/zgic_checker.sv
// Port-level checks on the integrity checker, bound to the top level.
`default_nettype none

module zgic_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire zgic_pkg::req_payload_type req_payload,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire zgic_pkg::rsp_payload_type rsp_payload
);
   import zgic_pkg::*;

   // Reset leaves no result beat behind.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat valid straight after reset");

   // The request side only stalls when a result beat is held up downstream.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without result backpressure");

   // A stalled request beat stays put until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> (req_valid && $stable(req_payload)))
      else $error("stalled request beat changed or vanished");

   // A stalled result beat stays put.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result beat changed or vanished");

   // Only the defined status codes ever appear.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status == STATUS_OK || rsp_payload.status == STATUS_HEADER_BAD
                  || rsp_payload.status == STATUS_METHOD_BAD
                  || rsp_payload.status == STATUS_CHECK_BAD
                  || rsp_payload.status == STATUS_SIZE_BAD))
      else $error("undefined status code on result beat");

endmodule

bind zlib_gzip_integrity_checker zgic_checker u_zgic_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_payload      (req_payload),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_payload      (rsp_payload)
);

`default_nettype wire

FILE: tb/zlib_gzip_integrity_checker_test.sv
// Self-checking testbench for the zlib/gzip integrity checker with a built-in checksum predictor.
module zlib_gzip_integrity_checker_test;
   timeunit 1ns;
   timeprecision 1ps;

   import zgic_pkg::*;

   localparam logic [1:0] CMD_UNUSED     = 2'd3;
   localparam logic [1:0] MODE_SPARE     = 2'd3;
   localparam int         HEADER_DIVISOR = 31;
   localparam int         LONG_HOLD      = 80;
   localparam int         STALL_LIMIT    = 1000;
   localparam int         PHASE_COUNT    = 8;
   localparam int         PHASE_ITEMS    = 120;

   typedef enum int {
      TRAILER_GOOD,
      TRAILER_BAD_CHECK,
      TRAILER_BAD_SIZE,
      TRAILER_BAD_BOTH,
      TRAILER_RANDOM
   } trailer_kind_type;

   logic            clock;
   logic            reset            = 1'b1;
   logic            req_valid        = 1'b0;
   logic            req_stall;
   req_payload_type req_payload      = '0;
   logic            rsp_valid;
   logic            rsp_stall        = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_write_enable = 1'b0;
   logic [1:0]      csr_write_data   = 2'd0;

   req_payload_type pending_items [$];
   rsp_payload_type expected_results [$];

   // Predictor state: Adler-32 kept as {high, low}, CRC register uninverted.
   logic [1:0]  model_mode  = MODE_RAW;
   logic [31:0] model_adler = 32'd1;
   logic [31:0] model_crc   = ALL_ONES;
   logic [31:0] model_total = '0;

   // Shadow of the same sums on the generating side, used to build trailers.
   logic [1:0]  gen_mode  = MODE_RAW;
   logic [31:0] gen_adler = 32'd1;
   logic [31:0] gen_crc   = ALL_ONES;
   logic [31:0] gen_count = '0;

   int sender_slack     = 0;
   int receiver_slack   = 0;
   int sender_hold      = 0;
   int receiver_hold    = 0;
   int long_holds_asked = 0;
   int long_holds_done  = 0;
   int items_queued     = 0;
   int requests_taken   = 0;
   int results_checked  = 0;
   int failures         = 0;

   zlib_gzip_integrity_checker u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] adler_next(input logic [31:0] sums, input logic [7:0] octet);
      logic [16:0] lo;
      logic [16:0] hi;
      lo = {1'b0, sums[15:0]} + {9'd0, octet};
      if (lo >= ADLER_MOD) lo = lo - ADLER_MOD;
      hi = {1'b0, sums[31:16]} + lo;
      if (hi >= ADLER_MOD) hi = hi - ADLER_MOD;
      return {hi[15:0], lo[15:0]};
   endfunction

   function automatic logic [31:0] crc_next(input logic [31:0] crc, input logic [7:0] octet);
      logic [31:0] c;
      c = crc ^ {24'd0, octet};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) c = (c >> 1) ^ CRC_POLY;
         else c = c >> 1;
      end
      return c;
   endfunction

   function automatic int pick_gap(input int slack);
      if (slack == 0 || $urandom_range(0, 1) == 0) return 0;
      return $urandom_range(0, slack);
   endfunction

   // Works out the result beat for one request and advances the predictor state.
   function automatic rsp_payload_type predict_integrity(input req_payload_type r);
      rsp_payload_type o;
      logic zlib_on;
      logic gzip_on;
      zlib_on = (model_mode == MODE_ZLIB);
      gzip_on = (model_mode == MODE_GZIP);
      o.status = STATUS_OK;
      case (r.cmd)
         CMD_BEGIN: begin
            model_adler = 32'd1;
            model_crc = ALL_ONES;
            model_total = '0;
            if (zlib_on) begin
               if (r.header_word % HEADER_DIVISOR != 0) o.status = STATUS_HEADER_BAD;
               else if (r.header_word[11:8] != METHOD_DEFLATE) o.status = STATUS_METHOD_BAD;
            end
         end
         CMD_DATA: begin
            if (zlib_on) begin
               model_adler = adler_next(model_adler, r.data_byte);
            end else if (gzip_on) begin
               model_crc = crc_next(model_crc, r.data_byte);
               model_total = model_total + 32'd1;
            end
         end
         CMD_TRAILER: begin
            if (zlib_on) begin
               if (r.trailer_check != model_adler) o.status = STATUS_CHECK_BAD;
            end else if (gzip_on) begin
               if (r.trailer_check != ~model_crc) o.status = STATUS_CHECK_BAD;
               else if (r.trailer_size != model_total) o.status = STATUS_SIZE_BAD;
            end
         end
         default: ;
      endcase
      if (zlib_on) o.running_check = model_adler;
      else if (gzip_on) o.running_check = model_crc;
      else o.running_check = '0;
      return o;
   endfunction

   task automatic enqueue_item(input logic [1:0] op, input logic [7:0] octet,
                               input logic [15:0] hdr, input logic [31:0] chk,
                               input logic [31:0] size);
      req_payload_type p;
      p.cmd = op;
      p.data_byte = octet;
      p.header_word = hdr;
      p.trailer_check = chk;
      p.trailer_size = size;
      pending_items.push_back(p);
      items_queued++;
      if (op == CMD_BEGIN) begin
         gen_adler = 32'd1;
         gen_crc = ALL_ONES;
         gen_count = '0;
      end else if (op == CMD_DATA) begin
         if (gen_mode == MODE_ZLIB) begin
            gen_adler = adler_next(gen_adler, octet);
         end else if (gen_mode == MODE_GZIP) begin
            gen_crc = crc_next(gen_crc, octet);
            gen_count = gen_count + 32'd1;
         end
      end
   endtask

   task automatic enqueue_trailer(input trailer_kind_type kind);
      logic [31:0] good_chk;
      logic [31:0] flip;
      good_chk = (gen_mode == MODE_ZLIB) ? gen_adler : ~gen_crc;
      flip = $urandom;
      if (flip == 0) flip = 32'd1;
      case (kind)
         TRAILER_GOOD:      enqueue_item(CMD_TRAILER, 8'd0, 16'd0, good_chk, gen_count);
         TRAILER_BAD_CHECK: enqueue_item(CMD_TRAILER, 8'd0, 16'd0, good_chk ^ flip, gen_count);
         TRAILER_BAD_SIZE:  enqueue_item(CMD_TRAILER, 8'd0, 16'd0, good_chk, gen_count ^ flip);
         TRAILER_BAD_BOTH:  enqueue_item(CMD_TRAILER, 8'd0, 16'd0, good_chk ^ flip,
                                         gen_count ^ {flip[0], flip[31:1]});
         default:           enqueue_item(CMD_TRAILER, 8'($urandom), 16'($urandom),
                                         $urandom, $urandom);
      endcase
   endtask

   // One stream: mostly begin, bytes, trailer; sometimes without its begin or trailer.
   task automatic enqueue_stream(input int nbytes, input logic all_ones);
      logic [15:0] hdr;
      logic [3:0]  window;
      logic [2:0]  flags;
      int          roll;
      if ($urandom_range(0, 9) != 0) begin
         window = 4'($urandom);
         flags = 3'($urandom);
         hdr = {window, METHOD_DEFLATE, flags, 5'd0};
         hdr = hdr | 16'((HEADER_DIVISOR - hdr % HEADER_DIVISOR) % HEADER_DIVISOR);
         if ($urandom_range(0, 4) == 0) hdr = 16'($urandom);
         enqueue_item(CMD_BEGIN, 8'($urandom), hdr, $urandom, $urandom);
      end
      for (int i = 0; i < nbytes; i++) begin
         if ($urandom_range(0, 15) == 0) begin
            enqueue_item(CMD_UNUSED, 8'($urandom), 16'($urandom), $urandom, $urandom);
         end
         enqueue_item(CMD_DATA, all_ones ? 8'hFF : 8'($urandom), 16'($urandom),
                      $urandom, $urandom);
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) enqueue_trailer(TRAILER_GOOD);
      else if (roll < 70) enqueue_trailer(TRAILER_BAD_CHECK);
      else if (roll < 85) enqueue_trailer(TRAILER_BAD_SIZE);
      else if (roll < 90) enqueue_trailer(TRAILER_BAD_BOTH);
      else if (roll < 95) enqueue_trailer(TRAILER_RANDOM);
   endtask

   // Sampled on the falling edge so that every process of the rising edge has finished.
   task automatic wait_for_idle();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_results.size() != 0);
   endtask

   task automatic set_container_mode(input logic [1:0] mode);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= mode;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      model_mode = mode;
      gen_mode = mode;
   endtask

   always @(posedge clock) begin : request_driver
      if (reset) begin
         req_valid <= 1'b0;
         sender_hold <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(predict_integrity(req_payload));
            requests_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (sender_hold > 0) begin
               req_valid <= 1'b0;
               sender_hold <= sender_hold - 1;
            end else if (pending_items.size() != 0) begin
               req_payload <= pending_items.pop_front();
               req_valid <= 1'b1;
               sender_hold <= pick_gap(sender_slack);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      int hold_next;
      rsp_payload_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         receiver_hold <= 0;
      end else begin
         hold_next = receiver_hold;
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (expected_results.size() == 0) begin
               $error("result beat with nothing outstanding: status %0d running_check %h",
                      rsp_payload.status, rsp_payload.running_check);
               failures++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_payload.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_payload.status);
                  failures++;
               end
               if (rsp_payload.running_check !== want.running_check) begin
                  $error("running_check: expected %h, actual %h",
                         want.running_check, rsp_payload.running_check);
                  failures++;
               end
            end
            hold_next = pick_gap(receiver_slack);
         end
         // A requested long hold overrides the per-beat draw.
         if (long_holds_done != long_holds_asked) begin
            hold_next = LONG_HOLD;
            long_holds_done++;
         end
         if (hold_next > 0) begin
            rsp_stall <= 1'b1;
            receiver_hold <= hold_next - 1;
         end else begin
            rsp_stall <= 1'b0;
            receiver_hold <= 0;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("No beat accepted for %0d cycles.", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      logic [1:0] phase_mode;
      int         target;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part: field extremes, every command and mode, each status.
      sender_slack = 3;
      receiver_slack = 3;
      set_container_mode(MODE_RAW);
      enqueue_item(CMD_BEGIN, 8'h00, 16'hFFFF, '0, '0);
      enqueue_item(CMD_DATA, 8'hFF, 16'h0000, '0, '0);
      enqueue_item(CMD_TRAILER, 8'h00, 16'h0000, ALL_ONES, ALL_ONES);
      enqueue_item(CMD_UNUSED, 8'hFF, 16'hFFFF, ALL_ONES, ALL_ONES);
      wait_for_idle();
      set_container_mode(MODE_ZLIB);
      enqueue_item(CMD_BEGIN, 8'h00, 16'h0001, '0, '0);
      enqueue_item(CMD_BEGIN, 8'h00, 16'h0000, '0, '0);
      enqueue_item(CMD_BEGIN, 8'h00, 16'hFFFF, '0, '0);
      enqueue_item(CMD_BEGIN, 8'h00, 16'h789C, '0, '0);
      enqueue_item(CMD_DATA, 8'h00, 16'h0000, '0, '0);
      enqueue_item(CMD_DATA, 8'hFF, 16'h0000, '0, '0);
      enqueue_item(CMD_DATA, 8'h80, 16'h0000, '0, '0);
      enqueue_item(CMD_UNUSED, 8'hFF, 16'hFFFF, ALL_ONES, ALL_ONES);
      enqueue_trailer(TRAILER_BAD_CHECK);
      enqueue_trailer(TRAILER_GOOD);
      wait_for_idle();
      set_container_mode(MODE_GZIP);
      enqueue_item(CMD_BEGIN, 8'h00, 16'h1F8B, '0, '0);
      enqueue_item(CMD_DATA, 8'h00, 16'h0000, '0, '0);
      enqueue_item(CMD_DATA, 8'hFF, 16'h0000, '0, '0);
      enqueue_trailer(TRAILER_GOOD);
      enqueue_item(CMD_TRAILER, 8'h00, 16'h0000, ~gen_crc, ALL_ONES);
      enqueue_trailer(TRAILER_BAD_BOTH);
      enqueue_item(CMD_TRAILER, 8'h00, 16'h0000, '0, '0);
      wait_for_idle();
      set_container_mode(MODE_SPARE);
      enqueue_item(CMD_BEGIN, 8'h00, 16'h0001, '0, '0);
      enqueue_item(CMD_DATA, 8'h5A, 16'h0000, '0, '0);
      enqueue_item(CMD_TRAILER, 8'h00, 16'h0000, 32'h1234_5678, 32'd7);
      wait_for_idle();

      // Random part: mostly well-formed streams with random content, plus stray beats.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0, 5, 7: phase_mode = MODE_GZIP;
            1, 3, 6: phase_mode = MODE_ZLIB;
            2:       phase_mode = MODE_RAW;
            default: phase_mode = MODE_SPARE;
         endcase
         sender_slack = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 18 : 5);
         receiver_slack = ((phase + 1) % 3 == 0) ? 0 : (((phase + 1) % 3 == 1) ? 18 : 5);
         set_container_mode(phase_mode);
         target = items_queued + PHASE_ITEMS;
         // Enough 0xFF bytes to push the low Adler sum past the modulus.
         if (phase == 1) enqueue_stream(262, 1'b1);
         while (items_queued < target) begin
            if ($urandom_range(0, 9) == 0) begin
               enqueue_item(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom),
                            $urandom, $urandom);
            end else begin
               enqueue_stream($urandom_range(0, 24), 1'b0);
            end
            // The queue holds pending items here, so a long receiver hold backs up the input.
            if (phase == 3 && long_holds_asked == 0) long_holds_asked++;
            if ($urandom_range(0, 7) == 0) wait_for_idle();
         end
         wait_for_idle();
      end

      repeat (4) @(posedge clock);
      $display("Covered %0d request beats and %0d result beats across raw, zlib, gzip",
               requests_taken, results_checked);
      $display("and the spare mode setting, with matching and failing trailers; %0d errors.",
               failures);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
